@@ src/rofs_pkg.sv @@
// Shared types and constants for the relay output feedback supervisor.
// Scan and result word layouts and the per-channel flag record.
// No dependencies.
package rofs_pkg;

    localparam int unsigned CH_W      = 6;
    localparam int unsigned TS_W      = 32;
    localparam int unsigned TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    // One scan of one output channel
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            wanted_level;
        logic            has_feedback;
        logic            feedback_level;
        logic            blocked;
        logic [TS_W-1:0] timestamp;
    } t_scan;

    // Per-scan result word
    typedef struct packed {
        logic            driven_level;
        logic            change_event;
        logic [CH_W-1:0] event_channel;
        logic [TS_W-1:0] event_time;
        logic            fail_when_high;
        logic            fail_when_low;
    } t_result;

    // Per-channel one-bit state
    typedef struct packed {
        logic level;
        logic active;
        logic fail_high;
        logic fail_low;
    } t_flags;

endpackage

@@ src/rofs_ifs.sv @@
// Valid/ready stream interfaces for scan words and result words.
// Depends on rofs_pkg.
interface rofs_scan_if
    import rofs_pkg::*;
;
    logic  valid;
    logic  ready;
    t_scan data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rofs_result_if
    import rofs_pkg::*;
;
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/rofs_state.sv @@
// Per-channel state memory: flags and timer count, one read and one write port.
// Valid bits make never-written channels read as zero after reset.
// Depends on rofs_pkg.
module rofs_state
    import rofs_pkg::*;
#(
    parameter int unsigned CHANNELS   = 64,
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(CHANNELS)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(CHANNELS)-1:0] i_wr_addr,
    input  t_flags                      i_wr_flags,
    input  logic [TIMER_BITS-1:0]       i_wr_count,
    output t_flags                      o_rd_flags,
    output logic [TIMER_BITS-1:0]       o_rd_count
);

    t_flags                mem_flags [CHANNELS];
    logic [TIMER_BITS-1:0] mem_count [CHANNELS];
    logic [CHANNELS-1:0]   r_vld;

    t_flags                r_rd_flags;
    logic [TIMER_BITS-1:0] r_rd_count;
    logic                  r_rd_ok;
    logic                  fwd;

    // write in the same cycle to the address being read
    assign fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    // memory write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_flags[i_wr_addr] <= i_wr_flags;
            mem_count[i_wr_addr] <= i_wr_count;
        end
    end

    // registered read with write forwarding
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (fwd) begin
                r_rd_flags <= i_wr_flags;
                r_rd_count <= i_wr_count;
            end else begin
                r_rd_flags <= mem_flags[i_rd_addr];
                r_rd_count <= mem_count[i_rd_addr];
            end
        end
    end

    // written-since-reset bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= fwd || r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_flags = r_rd_ok ? r_rd_flags : '0;
    assign o_rd_count = r_rd_ok ? r_rd_count : '0;

endmodule

@@ src/rofs_update.sv @@
// Next-state and result logic for one channel scan.
// Pure combinational; depends on rofs_pkg.
module rofs_update
    import rofs_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
) (
    input  t_scan                  i_scan,
    input  logic                   i_in_range,
    input  t_flags                 i_flags,
    input  logic [TIMER_BITS-1:0]  i_count,
    input  logic [TIMEOUT_W-1:0]   i_timeout,
    output t_flags                 o_flags,
    output logic [TIMER_BITS-1:0]  o_count,
    output t_result                o_result
);

    localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

    logic [CMP_W-1:0] lim_max;
    logic [CMP_W-1:0] lim_cfg;
    logic [CMP_W-1:0] limit;
    logic             lvl;
    logic             changed;

    // effective timeout is capped at the counter's maximum
    assign lim_max = CMP_W'({TIMER_BITS{1'b1}});
    assign lim_cfg = CMP_W'(i_timeout);
    assign limit   = (lim_cfg > lim_max) ? lim_max : lim_cfg;

    assign lvl     = i_scan.blocked ? 1'b0 : i_scan.wanted_level;
    assign changed = i_flags.level != lvl;

    // level and feedback timer update
    always_comb begin
        o_flags       = i_flags;
        o_count       = i_count;
        o_flags.level = lvl;
        if (i_scan.blocked) begin
            o_count = '0;
        end else begin
            if (changed && i_scan.has_feedback) begin
                o_flags.active = 1'b1;
                o_count        = '0;
            end
            if (i_scan.has_feedback && o_flags.active) begin
                if (CMP_W'(o_count) < limit) begin
                    o_count = o_count + TIMER_BITS'(1);
                    if (lvl == i_scan.feedback_level) begin
                        o_flags.active = 1'b0;
                        o_count        = '0;
                        if (lvl) begin
                            o_flags.fail_high = 1'b0;
                        end else begin
                            o_flags.fail_low = 1'b0;
                        end
                    end
                end else begin
                    // timed out
                    o_flags.active = 1'b0;
                    o_count        = '0;
                    if (lvl) begin
                        o_flags.fail_high = 1'b1;
                    end else begin
                        o_flags.fail_low = 1'b1;
                    end
                end
            end
        end
    end

    // result word; all zero for a channel outside the bank
    always_comb begin
        o_result = '0;
        if (i_in_range) begin
            o_result.driven_level   = lvl;
            o_result.change_event   = changed;
            o_result.event_channel  = changed ? i_scan.channel : '0;
            o_result.event_time     = changed ? i_scan.timestamp : '0;
            o_result.fail_when_high = o_flags.fail_high;
            o_result.fail_when_low  = o_flags.fail_low;
        end
    end

endmodule

@@ src/relay_output_feedback_supervisor.sv @@
// Relay output feedback supervisor, top level.
// A scan word and its state read are registered in the input stage, then the result register.
// Throughput: one scan word per cycle unless the result output stalls, set by the single state
// memory port pair with same-channel forwarding between back-to-back words.
// Reset: synchronous, active low; all channel state reads as zero at once via
// valid bits (no clearing pass), feedback timeout returns to 100.
module relay_output_feedback_supervisor
    import rofs_pkg::*;
#(
    parameter int unsigned CHANNELS   = 64,
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] i_cfg_wr_data,
    rofs_scan_if.sink            i_scan,
    rofs_result_if.source        o_result
);

    localparam int unsigned IDX_W = $clog2(CHANNELS);
    localparam int unsigned EXT_W = ((IDX_W > CH_W) ? IDX_W : CH_W) + 1;

    logic [TIMEOUT_W-1:0]  r_timeout;
    logic                  r_s1_vld;
    t_scan                 r_s1;
    logic                  r_s1_in_range;
    logic [IDX_W-1:0]      r_s1_addr;
    logic                  r_out_vld;
    t_result               r_out;

    logic                  accept;
    logic                  s1_adv;
    logic [EXT_W-1:0]      ch_ext;
    logic                  in_range;
    logic [IDX_W-1:0]      in_addr;
    t_flags                rd_flags;
    logic [TIMER_BITS-1:0] rd_count;
    t_flags                n_flags;
    logic [TIMER_BITS-1:0] n_count;
    t_result               n_out;

    // handshakes
    assign s1_adv       = r_s1_vld && (!r_out_vld || o_result.ready);
    assign i_scan.ready = !r_s1_vld || s1_adv;
    assign accept       = i_scan.valid && i_scan.ready;

    // channel range check and memory address
    assign ch_ext   = EXT_W'(i_scan.data.channel);
    assign in_range = ch_ext < EXT_W'(CHANNELS);
    assign in_addr  = ch_ext[IDX_W-1:0];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    rofs_state #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept && in_range),
        .i_rd_addr  (in_addr),
        .i_wr_en    (s1_adv && r_s1_in_range),
        .i_wr_addr  (r_s1_addr),
        .i_wr_flags (n_flags),
        .i_wr_count (n_count),
        .o_rd_flags (rd_flags),
        .o_rd_count (rd_count)
    );

    // input stage: scan word alongside the state read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1          <= i_scan.data;
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
        end
    end

    rofs_update #(
        .TIMER_BITS (TIMER_BITS)
    ) u_update (
        .i_scan     (r_s1),
        .i_in_range (r_s1_in_range),
        .i_flags    (rd_flags),
        .i_count    (rd_count),
        .i_timeout  (r_timeout),
        .o_flags    (n_flags),
        .o_count    (n_count),
        .o_result   (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the relay output feedback supervisor: scan words go in,
// result words are checked field by field against a per-channel level/timer predictor.
// Depends on rofs_pkg, rofs_ifs and relay_output_feedback_supervisor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rofs_pkg::*;

    localparam int unsigned CHANNEL_COUNT = 64;
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned DRAIN_PAD     = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [TIMEOUT_W-1:0] i_cfg_wr_data;

    rofs_scan_if   scan_bus ();
    rofs_result_if result_bus ();

    relay_output_feedback_supervisor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_scan        (scan_bus),
        .o_result      (result_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted per-channel state and the feedback timeout register
    logic                 level_q     [CHANNEL_COUNT];
    logic                 timer_run   [CHANNEL_COUNT];
    logic [TIMEOUT_W-1:0] timer_cnt   [CHANNEL_COUNT];
    logic                 fail_hi_q   [CHANNEL_COUNT];
    logic                 fail_lo_q   [CHANNEL_COUNT];
    logic [TIMEOUT_W-1:0] fb_timeout;

    t_result     expected_results [$];
    int unsigned fault_count  = 0;
    int unsigned result_count = 0;
    int unsigned cycle_count  = 0;

    // Traffic shaping shared by sender and receiver
    bit          idle_on   = 1'b0;
    int unsigned hold_len  = 0;
    int unsigned hold_ask  = 0;
    int unsigned hold_done = 0;

    task automatic report_fault(string msg);
        fault_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_fault($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   result_count, name, got, want));
    endtask

    // Expected result of one scan word; advances the predicted channel state
    function automatic t_result predict_scan(t_scan s);
        t_result     r;
        logic        lvl;
        logic        changed;
        int unsigned ch;
        r  = '0;
        ch = int'(s.channel);
        if (s.blocked) begin
            lvl           = 1'b0;
            changed       = level_q[ch] != lvl;
            level_q[ch]   = lvl;
            timer_cnt[ch] = '0;
        end else begin
            lvl         = s.wanted_level;
            changed     = level_q[ch] != lvl;
            level_q[ch] = lvl;
            if (changed && s.has_feedback) begin
                timer_run[ch] = 1'b1;
                timer_cnt[ch] = '0;
            end
            // counter never exceeds the 16-bit timeout, so no clamp is needed
            if (s.has_feedback && timer_run[ch]) begin
                if (timer_cnt[ch] < fb_timeout) begin
                    timer_cnt[ch] = timer_cnt[ch] + 1'b1;
                    if (lvl == s.feedback_level) begin
                        timer_run[ch] = 1'b0;
                        timer_cnt[ch] = '0;
                        if (lvl) fail_hi_q[ch] = 1'b0;
                        else     fail_lo_q[ch] = 1'b0;
                    end
                end else begin
                    timer_run[ch] = 1'b0;
                    timer_cnt[ch] = '0;
                    if (lvl) fail_hi_q[ch] = 1'b1;
                    else     fail_lo_q[ch] = 1'b1;
                end
            end
        end
        r.driven_level   = lvl;
        r.change_event   = changed;
        r.event_channel  = changed ? s.channel : '0;
        r.event_time     = changed ? s.timestamp : '0;
        r.fail_when_high = fail_hi_q[ch];
        r.fail_when_low  = fail_lo_q[ch];
        return r;
    endfunction

    // Scoreboard: predict on each accepted scan word, check each accepted result word
    always @(posedge i_clk) begin : scoreboard
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (scan_bus.valid && scan_bus.ready)
                expected_results.push_back(predict_scan(scan_bus.data));
            if (result_bus.valid && result_bus.ready) begin
                seen = result_bus.data;
                if (expected_results.size() == 0) begin
                    report_fault($sformatf("result %0d arrived with nothing pending",
                                           result_count));
                end else begin
                    want = expected_results.pop_front();
                    check_field("driven_level", 32'(seen.driven_level),
                                32'(want.driven_level));
                    check_field("change_event", 32'(seen.change_event),
                                32'(want.change_event));
                    check_field("event_channel", 32'(seen.event_channel),
                                32'(want.event_channel));
                    check_field("event_time", seen.event_time, want.event_time);
                    check_field("fail_when_high", 32'(seen.fail_when_high),
                                32'(want.fail_when_high));
                    check_field("fail_when_low", 32'(seen.fail_when_low),
                                32'(want.fail_when_low));
                end
                result_count++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result sink: random stalls, plus a long hold-off on request
    initial begin : result_sink
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ask != hold_done) begin
                result_bus.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_done++;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic apply_reset();
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        scan_bus.valid <= 1'b0;
        scan_bus.data  <= '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            level_q[c]   = 1'b0;
            timer_run[c] = 1'b0;
            timer_cnt[c] = '0;
            fail_hi_q[c] = 1'b0;
            fail_lo_q[c] = 1'b0;
        end
        fb_timeout = TIMEOUT_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Offer one scan word, optionally after a random gap, and wait for acceptance
    task automatic send_scan(t_scan s);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            scan_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        scan_bus.valid <= 1'b1;
        scan_bus.data  <= s;
        do @(posedge i_clk); while (!scan_bus.ready);
    endtask

    // Stop offering and wait until every expected word has come back
    task automatic wait_results_drained();
        scan_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Timeout register is only written with the block idle
    task automatic set_timeout(logic [TIMEOUT_W-1:0] value);
        wait_results_drained();
        repeat (DRAIN_PAD) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fb_timeout = value;
    endtask

    function automatic t_scan make_scan(logic [CH_W-1:0] ch, logic want, logic sup,
                                        logic fb, logic blk, logic [TS_W-1:0] ts);
        t_scan s;
        s.channel        = ch;
        s.wanted_level   = want;
        s.has_feedback   = sup;
        s.feedback_level = fb;
        s.blocked        = blk;
        s.timestamp      = ts;
        return s;
    endfunction

    // Mostly coherent per-channel traffic on a small pool of channels, rest is noise.
    // Stuck feedback on some channels lets timers run out; toggles restart them.
    task automatic run_scan_mix(int unsigned n_items, int unsigned pool_size,
                                int unsigned toggle_pct, bit with_gaps);
        t_scan           s;
        logic [CH_W-1:0] pool       [4];
        bit              wanted_now [CHANNEL_COUNT];
        bit              sup_map    [CHANNEL_COUNT];
        bit              stuck_map  [CHANNEL_COUNT];
        bit              stuck_val  [CHANNEL_COUNT];
        int unsigned     ch;
        idle_on = with_gaps;
        for (int c = 0; c < CHANNEL_COUNT; c++) wanted_now[c] = level_q[c];
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                foreach (pool[j]) pool[j] = CH_W'($urandom_range(0, CHANNEL_COUNT - 1));
                foreach (sup_map[c]) begin
                    sup_map[c]   = $urandom_range(0, 3) != 0;
                    stuck_map[c] = $urandom_range(0, 2) == 0;
                    stuck_val[c] = 1'($urandom_range(0, 1));
                end
                if (with_gaps) idle_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 9) < 8) begin
                ch = int'(pool[$urandom_range(0, pool_size - 1)]);
                if ($urandom_range(0, 99) < toggle_pct) wanted_now[ch] = ~wanted_now[ch];
                s.channel        = CH_W'(ch);
                s.wanted_level   = wanted_now[ch];
                s.has_feedback   = sup_map[ch] ? ($urandom_range(0, 15) != 0)
                                               : ($urandom_range(0, 15) == 0);
                if (stuck_map[ch])
                    s.feedback_level = stuck_val[ch];
                else
                    s.feedback_level = ($urandom_range(0, 2) == 0) ? s.wanted_level
                                                                   : ~s.wanted_level;
                s.blocked        = $urandom_range(0, 39) == 0;
            end else begin
                s.channel        = CH_W'($urandom_range(0, CHANNEL_COUNT - 1));
                s.wanted_level   = 1'($urandom_range(0, 1));
                s.has_feedback   = 1'($urandom_range(0, 1));
                s.feedback_level = 1'($urandom_range(0, 1));
                s.blocked        = 1'($urandom_range(0, 1));
            end
            s.timestamp = $urandom();
            send_scan(s);
        end
    endtask

    // Field extremes, zero timeout, timer expiry, unsupervised and blocked scans
    task automatic test_directed_cases();
        idle_on = 1'b1;
        // reset timeout: change starts timer, matching feedback clears it
        send_scan(make_scan(6'd0, 1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
        send_scan(make_scan(6'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0000));
        // unsupervised channel, then blocked forces level low
        send_scan(make_scan(6'd63, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000));
        send_scan(make_scan(6'd63, 1'b1, 1'b1, 1'b1, 1'b1, 32'h5555_AAAA));
        send_scan(make_scan(6'd63, 1'b0, 1'b1, 1'b1, 1'b0, 32'hAAAA_5555));
        // zero timeout: fails on first check even when feedback matches
        set_timeout('0);
        send_scan(make_scan(6'd5, 1'b1, 1'b1, 1'b1, 1'b0, 32'h1234_5678));
        send_scan(make_scan(6'd5, 1'b0, 1'b1, 1'b0, 1'b0, 32'h8765_4321));
        // timeout of two scans: expiry sets high fail, a later match clears it
        set_timeout(16'd2);
        send_scan(make_scan(6'd7, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0001));
        send_scan(make_scan(6'd7, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0002));
        send_scan(make_scan(6'd7, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0003));
        send_scan(make_scan(6'd7, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0004));
        send_scan(make_scan(6'd7, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0005));
        send_scan(make_scan(6'd7, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0006));
        // running timer is frozen across unsupervised scans
        send_scan(make_scan(6'd9, 1'b1, 1'b1, 1'b0, 1'b0, 32'hDEAD_BEEF));
        send_scan(make_scan(6'd9, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0010));
        send_scan(make_scan(6'd9, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0011));
        send_scan(make_scan(6'd9, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0012));
        send_scan(make_scan(6'd9, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0013));
        send_scan(make_scan(6'd9, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0014));
        // blocked scan clears the count but keeps the timer armed
        send_scan(make_scan(6'd10, 1'b1, 1'b1, 1'b0, 1'b0, 32'hCAFE_0000));
        send_scan(make_scan(6'd10, 1'b1, 1'b1, 1'b0, 1'b1, 32'hCAFE_0001));
        send_scan(make_scan(6'd10, 1'b0, 1'b1, 1'b1, 1'b0, 32'hCAFE_0002));
        send_scan(make_scan(6'd10, 1'b0, 1'b1, 1'b0, 1'b0, 32'hCAFE_0003));
    endtask

    // Default timeout, few channels and rare toggles so timers can expire
    task automatic test_slow_timeout();
        set_timeout(TIMEOUT_RESET);
        run_scan_mix(300, 2, 2, 1'b1);
    endtask

    task automatic test_zero_timeout();
        set_timeout('0);
        run_scan_mix(100, 4, 30, 1'b1);
    endtask

    task automatic test_short_timeouts();
        set_timeout(16'd1);
        run_scan_mix(150, 4, 20, 1'b1);
        set_timeout(16'd3);
        run_scan_mix(200, 4, 15, 1'b1);
    endtask

    task automatic test_max_timeout();
        set_timeout(16'hFFFF);
        run_scan_mix(100, 4, 20, 1'b1);
    endtask

    // Long sink hold-off fills the block, then a full pause until all words return
    task automatic test_backpressure();
        set_timeout(16'd5);
        hold_len = 80;
        hold_ask++;
        run_scan_mix(60, 4, 20, 1'b0);
        wait_results_drained();
        run_scan_mix(60, 4, 20, 1'b0);
    endtask

    // Closing stretch at full rate, no gaps on either side
    task automatic test_steady_stream();
        set_timeout(16'd2);
        run_scan_mix(150, 4, 20, 1'b0);
    endtask

    initial begin
        apply_reset();
        test_directed_cases();
        test_slow_timeout();
        test_zero_timeout();
        test_short_timeouts();
        test_max_timeout();
        test_backpressure();
        test_steady_stream();
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
